### src/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro wraps one clocked implication with an asynchronous reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### src/ksat_pkg.sv
// Package for the keyed score accumulator table: field widths, codes,
// controller states and the request/result structs of the score update unit.
package ksat_pkg;

	localparam int KEY_W   = 22;
	localparam int SCORE_W = 32;
	localparam int INC_W   = 16;

	localparam logic signed [SCORE_W-1:0] THRESH_RESET = 32'sd80;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN    = 32'sh8000_0000;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                      mode;
		logic                      full;
		logic signed [SCORE_W-1:0] old_score;
		logic signed [INC_W-1:0]   inc;
		logic signed [SCORE_W-1:0] thresh;
	} upd_req_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      over;
		logic                      full;
	} upd_res_t;

endpackage

### src/ksat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ksat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/ksat_update.sv
// Score update unit: saturating add of the increment, clear mode and threshold test.
// Depends on ksat_pkg for the request and result structs.
module ksat_update import ksat_pkg::*; (
	input  upd_req_t req,
	output upd_res_t res
);

	logic [SCORE_W:0]   sum;
	logic [SCORE_W-1:0] sat;

	assign sum = {req.old_score[SCORE_W-1], req.old_score}
		+ {{(SCORE_W+1-INC_W){req.inc[INC_W-1]}}, req.inc};

	always_comb begin
		// top two bits disagree on overflow; clamp toward the sign of the sum
		case (sum[SCORE_W:SCORE_W-1])
			2'b01:   sat = SCORE_MAX;
			2'b10:   sat = SCORE_MIN;
			default: sat = sum[SCORE_W-1:0];
		endcase
	end

	always_comb begin
		res.full  = req.full;
		res.score = '0;
		res.over  = 1'b0;
		if (!req.full && req.mode == MODE_ADD) begin
			res.score = sat;
			res.over  = ($signed(sat) >= req.thresh);
		end
	end

endmodule

### src/keyed_score_accumulator_table.sv
// Keyed score accumulator table: linear search over the key RAM, one entry read per cycle.
// A request searches the entries in use one at a time, then the update is computed in ST_UPDATE
// and the result is loaded and the RAMs written in ST_FINISH.
// Only one request is in flight: a new one is accepted only in ST_IDLE, and a result still
// waiting at the output stalls the next one in ST_FINISH.
// Reset clears the entry count and control state and sets the threshold to 80; RAM is not cleared.
module keyed_score_accumulator_table import ksat_pkg::*; #(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic signed [SCORE_W-1:0] score_limit,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [KEY_W-1:0]          process_id,
	input  logic signed [INC_W-1:0]   score_increment,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [SCORE_W-1:0] current_score,
	output logic                      over_threshold,
	output logic                      table_full
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t state_q, state_d;

	logic                      mode_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [INC_W-1:0]   inc_q;
	logic signed [SCORE_W-1:0] thresh_q;

	logic [CW-1:0] used_q;
	logic [CW-1:0] ptr_q;
	logic          rd_pend_s1;
	logic [AW-1:0] rd_addr_s1;

	logic [AW-1:0]             idx_q;
	logic signed [SCORE_W-1:0] old_score_q;
	logic                      new_q;
	logic                      full_q;

	upd_res_t res_q;
	logic     out_valid_q;
	upd_res_t out_q;

	logic [KEY_W-1:0]   key_rdata;
	logic [SCORE_W-1:0] score_rdata;

	logic match, issue, search_done, room;
	logic in_fire, load_out, key_we, score_we;

	upd_req_t upd_req;
	upd_res_t upd_res;

	assign in_fire = in_valid && in_ready;
	assign match   = rd_pend_s1 && (key_rdata == key_q);
	assign issue   = (state_q == ST_SEARCH) && !match && (ptr_q < used_q);
	assign search_done = (state_q == ST_SEARCH) && (match || (!issue && !rd_pend_s1));
	assign room    = (used_q < CW'(TABLE_ENTRIES));

	ksat_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (idx_q),
		.wdata (key_q),
		.re    (issue),
		.raddr (ptr_q[AW-1:0]),
		.rdata (key_rdata)
	);

	ksat_ram #(.WIDTH(SCORE_W), .DEPTH(TABLE_ENTRIES)) u_score_ram (
		.clk   (clk),
		.we    (score_we),
		.waddr (idx_q),
		.wdata (res_q.score),
		.re    (issue),
		.raddr (ptr_q[AW-1:0]),
		.rdata (score_rdata)
	);

	assign upd_req.mode      = mode_q;
	assign upd_req.full      = full_q;
	assign upd_req.old_score = old_score_q;
	assign upd_req.inc       = inc_q;
	assign upd_req.thresh    = thresh_q;

	ksat_update u_update (
		.req (upd_req),
		.res (upd_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SEARCH;
			ST_SEARCH: if (search_done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		key_we   = 1'b0;
		score_we = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SEARCH: ;
			// res_q is written here, RAM takes it on the next edge from ST_FINISH
			ST_UPDATE: ;
			ST_FINISH: begin
				key_we   = new_q;
				score_we = !full_q;
				load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thresh_q    <= THRESH_RESET;
			used_q      <= '0;
			ptr_q       <= '0;
			rd_pend_s1  <= 1'b0;
			new_q       <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thresh_q <= score_limit;
			end
			if (in_fire) begin
				ptr_q      <= '0;
				rd_pend_s1 <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				rd_pend_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (search_done) begin
				if (match) begin
					new_q  <= 1'b0;
					full_q <= 1'b0;
				end else begin
					// append a fresh entry when room remains, otherwise report full
					new_q  <= room;
					full_q <= !room;
				end
			end
			if (state_q == ST_FINISH && new_q) begin
				used_q <= used_q + CW'(1);
				new_q  <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			key_q  <= process_id;
			inc_q  <= score_increment;
		end
		if (state_q == ST_SEARCH) begin
			rd_addr_s1 <= ptr_q[AW-1:0];
		end
		if (search_done) begin
			if (match) begin
				idx_q       <= rd_addr_s1;
				old_score_q <= score_rdata;
			end else begin
				idx_q       <= used_q[AW-1:0];
				old_score_q <= '0;
			end
		end
		if (state_q == ST_UPDATE) begin
			res_q <= upd_res;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_score  = out_q.score;
	assign over_threshold = out_q.over;
	assign table_full     = out_q.full;

endmodule

### src/ksat_checker.sv
// Port-level checker for keyed_score_accumulator_table, bound to the top level.
// Depends on assert_macros.svh and ksat_pkg.
`include "assert_macros.svh"

module ksat_checker import ksat_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [SCORE_W-1:0] current_score,
	input logic                      over_threshold,
	input logic                      table_full
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(current_score) && $stable(over_threshold) && $stable(table_full))
	`ASSERT_IMPL(a_full_zero, clk, arst_n, out_valid && table_full,
		current_score == '0 && !over_threshold)
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind keyed_score_accumulator_table ksat_checker u_ksat_checker (.*);

### tb/keyed_score_accumulator_table_test.sv
// Self-checking testbench for keyed_score_accumulator_table.
// Holds its own score table to predict each result, drives the request and result channels
// with random idling and writes the threshold in between. Depends on ksat_pkg and the block's RTL only.
module keyed_score_accumulator_table_test;
	import ksat_pkg::*;

	localparam int TABLE_DEPTH   = 128;
	localparam int POOL_SIZE     = 100;
	localparam int PHASE_ITEMS   = 400;
	localparam int STEADY_ITEMS  = 100;
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_LIMIT  = 100;
	localparam logic signed [INC_W-1:0] INC_MAX = 16'sh7FFF;
	localparam logic signed [INC_W-1:0] INC_MIN = 16'sh8000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic signed [SCORE_W-1:0] score_limit = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      mode = MODE_ADD;
	logic [KEY_W-1:0]          process_id = '0;
	logic signed [INC_W-1:0]   score_increment = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [SCORE_W-1:0] current_score;
	logic                      over_threshold;
	logic                      table_full;

	bit steady = 1'b0;
	int stall_cycles = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	keyed_score_accumulator_table #(.TABLE_ENTRIES(TABLE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.score_limit(score_limit),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.process_id(process_id),
		.score_increment(score_increment),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.current_score(current_score),
		.over_threshold(over_threshold),
		.table_full(table_full)
	);

	// Keeps a shadow of the key/score table and the expected results in order.
	class score_ledger;
		logic [KEY_W-1:0]          keys [TABLE_DEPTH];
		logic signed [SCORE_W-1:0] scores [TABLE_DEPTH];
		int                        used;
		logic signed [SCORE_W-1:0] threshold;
		upd_res_t                  expected_scores [$];
		int errors, requests, results, fulls, overs, clamps, clears;

		function new();
			used = 0;
			threshold = THRESH_RESET;
			errors = 0;
			requests = 0;
			results = 0;
			fulls = 0;
			overs = 0;
			clamps = 0;
			clears = 0;
		endfunction

		function void set_threshold(logic signed [SCORE_W-1:0] value);
			threshold = value;
		endfunction

		function int pending();
			return expected_scores.size();
		endfunction

		function void note_request(logic op, logic [KEY_W-1:0] key,
				logic signed [INC_W-1:0] inc);
			int slot;
			longint sum;
			upd_res_t want;
			slot = -1;
			want = '0;
			requests++;
			// first match wins, search only the entries in use
			for (int i = 0; i < used && slot < 0; i++)
				if (keys[i] == key)
					slot = i;
			if (slot < 0 && used < TABLE_DEPTH) begin
				slot = used;
				keys[slot] = key;
				scores[slot] = '0;
				used++;
			end
			if (slot < 0) begin
				want.full = 1'b1;
				fulls++;
			end else if (op == MODE_CLEAR) begin
				scores[slot] = '0;
				clears++;
			end else begin
				sum = longint'($signed(scores[slot])) + longint'($signed(inc));
				if (sum > longint'(SCORE_MAX)) begin
					sum = longint'(SCORE_MAX);
					clamps++;
				end else if (sum < longint'(SCORE_MIN)) begin
					sum = longint'(SCORE_MIN);
					clamps++;
				end
				scores[slot] = sum[SCORE_W-1:0];
				want.score = scores[slot];
				want.over = ($signed(scores[slot]) >= $signed(threshold));
				if (want.over)
					overs++;
			end
			expected_scores.push_back(want);
		endfunction

		function void report_mismatch(string field, longint want, longint got);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(logic signed [SCORE_W-1:0] score, logic over, logic full);
			upd_res_t want;
			results++;
			if (expected_scores.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: unexpected result, expected none, actual score %0d over %0b full %0b",
						$time, score, over, full);
				return;
			end
			want = expected_scores.pop_front();
			if (want.score !== score)
				report_mismatch("current_score", longint'($signed(want.score)),
					longint'($signed(score)));
			if (want.over !== over)
				report_mismatch("over_threshold", want.over, over);
			if (want.full !== full)
				report_mismatch("table_full", want.full, full);
		endfunction

		function void close_out();
			if (expected_scores.size() != 0) begin
				errors++;
				$display("%0t: %0d results missing, expected score %0d first, actual none",
					$time, expected_scores.size(), $signed(expected_scores[0].score));
			end
			if (errors > REPORT_LIMIT)
				$display("%0d mismatches in all, only the first %0d reported", errors,
					REPORT_LIMIT);
		endfunction
	endclass

	score_ledger book = new();

	initial begin
		forever #4 clk = ~clk;
	end

	// Receiver: stall at random unless in a steady stretch.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 10);

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				book.set_threshold(score_limit);
			if (in_valid && in_ready)
				book.note_request(mode, process_id, score_increment);
			if (out_valid && out_ready)
				book.check_result(current_score, over_threshold, table_full);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, stall_cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [KEY_W-1:0] key, logic signed [INC_W-1:0] inc);
		while (!steady && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		process_id <= key;
		score_increment <= inc;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off new requests until every expected result is back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	task automatic write_threshold(logic signed [SCORE_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		score_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Runs under the reset threshold of 80.
	task automatic run_directed();
		send_request(MODE_ADD, '0, INC_MAX);
		send_request(MODE_ADD, '0, INC_MIN);
		send_request(MODE_ADD, '1, 16'sd80);
		send_request(MODE_ADD, '1, -16'sd1);
		send_request(MODE_CLEAR, '1, INC_MAX);
		send_request(MODE_CLEAR, 22'h155555, INC_MIN);
		send_request(MODE_ADD, 22'h155555, 16'sd0);
		send_request(MODE_ADD, 22'h2AAAAA, 16'sd79);
		send_request(MODE_ADD, 22'h2AAAAA, 16'sd1);
		send_request(MODE_CLEAR, '0, 16'sd5);
		send_request(MODE_ADD, '0, INC_MIN);
		send_request(MODE_ADD, 22'h000001, INC_MAX);
		send_request(MODE_ADD, 22'h200000, 16'sh5555);
		send_request(MODE_ADD, 22'h200000, 16'shAAAA);
		send_request(MODE_ADD, 22'h155555, 16'sd100);
		send_request(MODE_CLEAR, 22'h000001, 16'sd0);
	endtask

	task automatic run_random(int count);
		logic op;
		logic [KEY_W-1:0] key;
		logic signed [INC_W-1:0] inc;
		int offset;
		repeat (count) begin
			op = ($urandom_range(99) < 15) ? MODE_CLEAR : MODE_ADD;
			if ($urandom_range(9) == 0)
				key = KEY_W'($urandom);
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			if ($urandom_range(9) < 3) begin
				offset = $urandom_range(400);
				inc = INC_W'(offset - 200);
			end else
				inc = INC_W'($urandom);
			if (!steady && $urandom_range(199) == 0)
				wait_drained();
			send_request(op, key, inc);
		end
	endtask

	// Extreme thresholds with no idling on either side.
	task automatic run_steady();
		steady = 1'b1;
		write_threshold(SCORE_MAX);
		run_random(STEADY_ITEMS);
		write_threshold(SCORE_MIN);
		run_random(STEADY_ITEMS);
		steady = 1'b0;
	endtask

	initial begin
		int spread;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 22'h155555;
		key_pool[3] = 22'h2AAAAA;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_steady();
		write_threshold('0);
		run_random(PHASE_ITEMS);
		write_threshold(SCORE_W'($urandom));
		run_random(PHASE_ITEMS);
		write_threshold(32'sd100);
		run_random(PHASE_ITEMS);
		spread = $urandom_range(100000);
		write_threshold(SCORE_W'(spread - 50000));
		run_random(PHASE_ITEMS);
		wait_drained();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		book.close_out();
		$display("covered %0d requests and %0d results: %0d table-full, %0d clears,",
			book.requests, book.results, book.fulls, book.clears);
		$display("%0d over threshold and %0d saturated adds, %0d table entries filled",
			book.overs, book.clamps, book.used);
		if (book.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### keyed_score_accumulator_table.f
+incdir+src
src/ksat_pkg.sv
src/ksat_ram.sv
src/ksat_update.sv
src/keyed_score_accumulator_table.sv
src/ksat_checker.sv
tb/keyed_score_accumulator_table_test.sv
